// ----- rtl/a2a_pkg.sv -----
// ----------------------------------------------------------------------------
// a2a_pkg
// Shared types and constants of the avcC to Annex B converter.
// ----------------------------------------------------------------------------
`default_nettype none
package a2a_pkg;
	localparam int StoreDepth = 56;
	localparam int StoreAw = $clog2(StoreDepth);
	localparam int CountW = $clog2(StoreDepth + 1);
	localparam int LengthBytes = 4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_REC_TRUNC = 3'd1;
	localparam logic [2:0] ST_OVERFLOW  = 3'd2;
	localparam logic [2:0] ST_PKT_TRUNC = 3'd3;
	localparam logic [2:0] ST_NO_SPS    = 3'd4;
	localparam logic [2:0] ST_NO_PPS    = 3'd5;

	localparam logic [4:0] NAL_IDR = 5'd5;

	// Output sequencer commands.
	typedef enum logic [2:0] {
		SRC_DATA   = 3'd0,
		SRC_ZERO   = 3'd1,
		SRC_ONE    = 3'd2,
		SRC_STORE  = 3'd3,
		SRC_STATUS = 3'd4
	} src_t;

	typedef struct packed {
		logic       load;      // capture input byte and plan
		logic       emit;      // drive an output item this cycle
		src_t       src;
		logic       is_last;
		logic       store_rst; // restart replay address
		logic       store_inc;
	} cmd_t;

	typedef struct packed {
		logic              replay;    // IDR replay needed
		logic              has_sc;    // start code needed
		logic              long_sc;   // four-byte start code
		logic              has_data;
		logic              has_stat;
		logic              store_end; // replay address reached count
		logic              wr_busy;   // start code still being written to the store
	} sts_t;
endpackage
`default_nettype wire

// ----- rtl/a2a_stream_if.sv -----
// ----------------------------------------------------------------------------
// a2a_in_if / a2a_out_if
// Valid/ready channels of the converter.
// ----------------------------------------------------------------------------
`default_nettype none
interface a2a_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] data_byte;
	logic       last;
	modport source (output valid, op, data_byte, last, input ready);
	modport sink (input valid, op, data_byte, last, output ready);
endinterface

interface a2a_out_if;
	logic       valid;
	logic       ready;
	logic       is_status;
	logic [7:0] out_byte;
	logic [2:0] status;
	logic [2:0] nal_length_size;
	logic       run_last;
	modport source (output valid, is_status, out_byte, status, nal_length_size, run_last,
		input ready);
	modport sink (input valid, is_status, out_byte, status, nal_length_size, run_last,
		output ready);
endinterface
`default_nettype wire

// ----- rtl/avcc_to_annexb_converter_core.sv -----
// ----------------------------------------------------------------------------
// avcc_to_annexb_converter_core
// Converts avcC configuration records and length-framed packets to Annex B.
// ----------------------------------------------------------------------------
// One input byte is taken at a time. Each byte is captured, then planned, then
// the output items it causes are issued one per cycle while the output register
// can take them: replayed parameter-set bytes, start code bytes, the data byte
// and a status item, in that order.
// A record byte that completes a unit size writes the four start code bytes
// into the store one per cycle; the next byte is not taken until all are written.
// The parameter-set store is a 56-byte array read one byte per cycle during
// replay; the sequencer stalls while a result waits in the output register.
`default_nettype none
module avcc_to_annexb_converter_core import a2a_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	a2a_in_if.sink   in_ch,
	a2a_out_if.source out_ch
);
	cmd_t cmd;
	sts_t sts;

	a2a_controller u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts, .cmd
	);

	a2a_datapath u_dp (
		.clk, .arst_n,
		.in_op(in_ch.op), .in_byte(in_ch.data_byte), .in_last(in_ch.last),
		.cmd, .sts,
		.out_ready(out_ch.ready), .out_valid(out_ch.valid),
		.out_is_status(out_ch.is_status), .out_byte(out_ch.out_byte),
		.out_status(out_ch.status), .out_nls(out_ch.nal_length_size),
		.out_run_last(out_ch.run_last)
	);
endmodule
`default_nettype wire

// ----- rtl/a2a_datapath.sv -----
// ----------------------------------------------------------------------------
// a2a_datapath
// Parsing state, parameter-set store and output register.
// ----------------------------------------------------------------------------
`default_nettype none
module a2a_datapath import a2a_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_op,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	input  wire cmd_t       cmd,
	output sts_t            sts,
	input  wire logic       out_ready,
	output logic            out_valid,
	output logic            out_is_status,
	output logic [7:0]      out_byte,
	output logic [2:0]      out_status,
	output logic [2:0]      out_nls,
	output logic            out_run_last
);
	localparam logic [3:0] RP_LENSIZE = 4'd4, RP_SPSCOUNT = 4'd5, RP_SIZEHI = 4'd6,
		RP_SIZELO = 4'd7, RP_BODY = 4'd8, RP_PPSCOUNT = 4'd9, RP_DONE = 4'd10;
	localparam logic [1:0] PP_LEN = 2'd0, PP_START = 2'd1, PP_BODY = 2'd2,
		PP_DISCARD = 2'd3;

	logic [7:0]        mem [StoreDepth];
	logic [CountW-1:0] count_q;
	logic [3:0]        rphase_q;
	logic [7:0]        units_q;
	logic [15:0]       ubytes_q;
	logic [2:0]        seen_q;
	logic [1:0]        pphase_q;
	logic [31:0]       accum_q;
	logic [31:0]       nleft_q;
	logic              first_q;
	logic [1:0]        bidx_q;
	logic [2:0]        nls_q;
	logic              err_q;

	// Captured item plan.
	logic [7:0]        byte_q;
	logic [2:0]        stat_q;
	logic              replay_q, sc_q, long_q, data_q, hstat_q;
	logic [CountW-1:0] raddr_q, raddr_d;
	logic [7:0]        rdata_q;

	// Start code bytes still to be written after the first one.
	logic [1:0]        sc_left_q;
	logic [CountW-1:0] sc_addr_q;
	logic              wr_go;
	logic [CountW-1:0] wr_addr;
	logic [7:0]        wr_val;

	// Next-state computation for the accepted byte.
	logic [CountW-1:0] n_count;
	logic [3:0]        n_rphase;
	logic [7:0]        n_units;
	logic [15:0]       n_ubytes;
	logic [2:0]        n_seen;
	logic [1:0]        n_pphase;
	logic [31:0]       n_accum, n_nleft, full;
	logic              n_first, n_err;
	logic [1:0]        n_bidx;
	logic [2:0]        n_nls, code;
	logic              p_replay, p_sc, p_data, p_stat;
	logic              wr_en;
	logic [7:0]        wr_data;
	logic [2:0]        wr_n;   // header writes this byte: 4, 1 or 0
	logic [15:0]       ub_dec;
	logic [7:0]        un_dec;

	always_comb begin
		n_count = count_q; n_rphase = rphase_q; n_units = units_q; n_ubytes = ubytes_q;
		n_seen = seen_q; n_pphase = pphase_q; n_accum = accum_q; n_nleft = nleft_q;
		n_first = first_q; n_bidx = bidx_q; n_nls = nls_q; n_err = err_q;
		p_replay = 1'b0; p_sc = 1'b0; p_data = 1'b0; p_stat = 1'b0; code = ST_OK;
		wr_en = 1'b0; wr_data = in_byte; wr_n = 3'd0;
		ub_dec = ubytes_q - 16'd1;
		un_dec = units_q - 8'd1;
		full = {accum_q[23:0], in_byte};
		if (!in_op) begin
			unique case (rphase_q)
				4'd0: begin
					n_count = '0; n_seen = '0; n_err = 1'b0; n_units = '0; n_rphase = 4'd1;
				end
				4'd1, 4'd2, 4'd3: n_rphase = rphase_q + 4'd1;
				RP_LENSIZE: begin
					n_nls = {1'b0, in_byte[1:0]} + 3'd1; n_rphase = RP_SPSCOUNT;
				end
				RP_SPSCOUNT: begin
					n_units = {3'b0, in_byte[4:0]};
					if (in_byte[4:0] == 5'd0) begin
						n_seen[2] = 1'b1; n_rphase = RP_PPSCOUNT;
					end else begin
						n_seen[0] = 1'b1; n_rphase = RP_SIZEHI;
					end
				end
				RP_SIZEHI: begin
					n_ubytes = {in_byte, 8'd0}; n_rphase = RP_SIZELO;
				end
				RP_SIZELO: begin
					n_ubytes = {ubytes_q[15:8], in_byte};
					wr_n = 3'd4;
					if (n_ubytes == 16'd0) begin
						n_units = un_dec;
						if (un_dec != 8'd0) n_rphase = RP_SIZEHI;
						else if (seen_q[2]) n_rphase = RP_DONE;
						else begin
							n_seen[2] = 1'b1; n_rphase = RP_PPSCOUNT;
						end
					end else n_rphase = RP_BODY;
				end
				RP_BODY: begin
					wr_n = 3'd1;
					n_ubytes = ub_dec;
					if (ub_dec == 16'd0) begin
						n_units = un_dec;
						if (un_dec != 8'd0) n_rphase = RP_SIZEHI;
						else if (seen_q[2]) n_rphase = RP_DONE;
						else begin
							n_seen[2] = 1'b1; n_rphase = RP_PPSCOUNT;
						end
					end
				end
				RP_PPSCOUNT: begin
					n_units = in_byte;
					if (in_byte == 8'd0) n_rphase = RP_DONE;
					else begin
						n_seen[1] = 1'b1; n_rphase = RP_SIZEHI;
					end
				end
				default: n_rphase = RP_DONE;
			endcase
			// The start code takes four store places; the count moves at once.
			if (wr_n == 3'd4) begin
				if (count_q <= CountW'(StoreDepth - 4)) n_count = count_q + CountW'(4);
				else begin
					n_count = CountW'(StoreDepth); n_err = 1'b1;
				end
			end else if (wr_n == 3'd1) begin
				if (count_q < CountW'(StoreDepth)) begin
					n_count = count_q + CountW'(1); wr_en = 1'b1;
				end else n_err = 1'b1;
			end
			if (in_last) begin
				p_stat = 1'b1;
				if (n_rphase != RP_DONE) code = ST_REC_TRUNC;
				else if (n_err) code = ST_OVERFLOW;
				else if (!n_seen[0]) code = ST_NO_SPS;
				else if (!n_seen[1]) code = ST_NO_PPS;
				else code = ST_OK;
				if (code == ST_REC_TRUNC || code == ST_OVERFLOW) begin
					n_count = '0; n_seen = '0;
				end
				n_rphase = 4'd0;
			end
		end else begin
			unique case (pphase_q)
				PP_LEN: begin
					n_accum = full;
					n_bidx = bidx_q + 2'd1;
					if (bidx_q == 2'(LengthBytes - 1)) begin
						n_bidx = '0; n_nleft = full; n_accum = '0;
						if (full[31]) n_pphase = PP_DISCARD;
						else if (full == 32'd0) begin
							p_sc = 1'b1; n_first = 1'b0;
						end else n_pphase = PP_START;
					end
				end
				PP_START, PP_BODY: begin
					if (pphase_q == PP_START) begin
						p_replay = (in_byte[4:0] == NAL_IDR) && (count_q != '0);
						p_sc = 1'b1; n_first = 1'b0;
					end
					p_data = 1'b1;
					n_nleft = nleft_q - 32'd1;
					n_pphase = (n_nleft == 32'd0) ? PP_LEN : PP_BODY;
				end
				default: ;
			endcase
			if (in_last) begin
				p_stat = 1'b1;
				code = (n_pphase == PP_LEN && n_bidx == 2'd0) ? ST_OK : ST_PKT_TRUNC;
				n_pphase = PP_LEN; n_bidx = '0; n_accum = '0; n_nleft = '0; n_first = 1'b1;
			end
		end
	end

	// One store write per cycle: the first start code byte goes in with the
	// size byte, the other three in the following cycles.
	always_comb begin
		wr_go = 1'b0; wr_addr = count_q; wr_val = wr_data;
		if (cmd.load && !in_op && wr_n == 3'd4) begin
			wr_go = (count_q < CountW'(StoreDepth)); wr_val = 8'd0;
		end else if (cmd.load && wr_en) begin
			wr_go = 1'b1;
		end else if (sc_left_q != 2'd0) begin
			wr_go = (sc_addr_q < CountW'(StoreDepth)); wr_addr = sc_addr_q;
			wr_val = (sc_left_q == 2'd1) ? 8'd1 : 8'd0;
		end
	end

	assign raddr_d = cmd.store_rst ? '0 :
		(cmd.store_inc ? raddr_q + CountW'(1) : raddr_q);

	// The read register always holds the byte at the current replay address.
	always_ff @(posedge clk) begin
		if (wr_go) mem[StoreAw'(wr_addr)] <= wr_val;
		rdata_q <= mem[StoreAw'(raddr_d)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0; rphase_q <= '0; units_q <= '0; ubytes_q <= '0; seen_q <= '0;
			pphase_q <= PP_LEN; accum_q <= '0; nleft_q <= '0; first_q <= 1'b1;
			bidx_q <= '0; nls_q <= 3'd4; err_q <= 1'b0; raddr_q <= '0;
			sc_left_q <= '0; sc_addr_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.load) begin
				count_q <= n_count; rphase_q <= n_rphase; units_q <= n_units;
				ubytes_q <= n_ubytes; seen_q <= n_seen; pphase_q <= n_pphase;
				accum_q <= n_accum; nleft_q <= n_nleft; first_q <= n_first;
				bidx_q <= n_bidx; nls_q <= n_nls; err_q <= n_err;
			end
			if (cmd.load && !in_op && wr_n == 3'd4) begin
				sc_left_q <= 2'd3; sc_addr_q <= count_q + CountW'(1);
			end else if (sc_left_q != 2'd0) begin
				sc_left_q <= sc_left_q - 2'd1; sc_addr_q <= sc_addr_q + CountW'(1);
			end
			raddr_q <= raddr_d;
			if (cmd.emit) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= in_byte; stat_q <= code; replay_q <= p_replay; sc_q <= p_sc;
			long_q <= first_q; data_q <= p_data; hstat_q <= p_stat;
		end
		if (cmd.emit) begin
			out_is_status <= (cmd.src == SRC_STATUS);
			out_run_last <= cmd.is_last;
			out_status <= (cmd.src == SRC_STATUS) ? stat_q : ST_OK;
			out_nls <= (cmd.src == SRC_STATUS) ? nls_q : 3'd0;
			unique case (cmd.src)
				SRC_DATA:  out_byte <= byte_q;
				SRC_ONE:   out_byte <= 8'd1;
				SRC_STORE: out_byte <= rdata_q;
				default:   out_byte <= 8'd0;
			endcase
		end
	end

	assign sts.replay = replay_q;
	assign sts.has_sc = sc_q;
	assign sts.long_sc = long_q;
	assign sts.has_data = data_q;
	assign sts.has_stat = hstat_q;
	assign sts.store_end = (raddr_q + CountW'(1) >= count_q);
	assign sts.wr_busy = (sc_left_q != 2'd0);

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CountW'(StoreDepth))
		else $error("store count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && cmd.src == SRC_STORE |-> raddr_q < count_q)
		else $error("replay read beyond fill");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output item dropped");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.load |-> sc_left_q == 2'd0)
		else $error("input taken while the store is being written");
endmodule
`default_nettype wire

// ----- rtl/a2a_controller.sv -----
// ----------------------------------------------------------------------------
// a2a_controller
// Sequences the output items that one input byte causes.
// ----------------------------------------------------------------------------
`default_nettype none
module a2a_controller import a2a_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire logic out_valid,
	input  wire logic out_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);
	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_PLAN   = 6'b000010,
		S_REPLAY = 6'b000100,
		S_SC     = 6'b001000,
		S_DATA   = 6'b010000,
		S_STAT   = 6'b100000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] sc_q, sc_d;
	logic       slot;

	// The output register may take a new item when it is empty or draining.
	assign slot = !out_valid || out_ready;

	always_comb begin
		state_d = state_q; sc_d = sc_q; cmd = '0; cmd.src = SRC_DATA;
		in_ready = (state_q == S_IDLE) && !sts.wr_busy;
		unique case (state_q)
			S_IDLE: if (in_valid && !sts.wr_busy) begin
				cmd.load = 1'b1; state_d = S_PLAN;
			end
			S_PLAN: begin
				cmd.store_rst = 1'b1;
				sc_d = sts.long_sc ? 2'd3 : 2'd2;
				if (sts.replay) state_d = S_REPLAY;
				else if (sts.has_sc) state_d = S_SC;
				else if (sts.has_data) state_d = S_DATA;
				else if (sts.has_stat) state_d = S_STAT;
				else state_d = S_IDLE;
			end
			S_REPLAY: if (slot) begin
				cmd.emit = 1'b1; cmd.src = SRC_STORE; cmd.store_inc = 1'b1;
				if (sts.store_end) state_d = S_SC;
			end
			S_SC: if (slot) begin
				cmd.emit = 1'b1;
				if (sc_q == 2'd0) begin
					cmd.src = SRC_ONE;
					cmd.is_last = !sts.has_data && !sts.has_stat;
					state_d = sts.has_data ? S_DATA : (sts.has_stat ? S_STAT : S_IDLE);
				end else begin
					cmd.src = SRC_ZERO; sc_d = sc_q - 2'd1;
				end
			end
			S_DATA: if (slot) begin
				cmd.emit = 1'b1; cmd.src = SRC_DATA; cmd.is_last = !sts.has_stat;
				state_d = sts.has_stat ? S_STAT : S_IDLE;
			end
			S_STAT: if (slot) begin
				cmd.emit = 1'b1; cmd.src = SRC_STATUS; cmd.is_last = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; sc_q <= '0;
		end else begin
			state_q <= state_d; sc_q <= sc_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.load |=> state_q == S_PLAN)
		else $error("plan step skipped");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.emit |-> !in_ready)
		else $error("input taken while emitting");
endmodule
`default_nettype wire

// ----- bench/avcc_to_annexb_converter_core_test.sv -----
// ----------------------------------------------------------------------------
// avcc_to_annexb_converter_core_test
// Drives avcC records and length-framed packets into the converter and checks
// every output item against a behavioral model of the conversion.
// ----------------------------------------------------------------------------
`default_nettype none
module avcc_to_annexb_converter_core_test;
	import a2a_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RecSkip0 = 0, RecLenSize = 4, RecSpsCount = 5, RecSizeHi = 6;
	localparam int RecSizeLo = 7, RecBody = 8, RecPpsCount = 9, RecDone = 10;
	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_PACKET = 1'b1;

	typedef enum int {PK_LEN, PK_START, PK_BODY, PK_DISCARD} pkt_phase_t;

	typedef struct packed {
		logic       is_status;
		logic [7:0] out_byte;
		logic [2:0] status;
		logic [2:0] nal_length_size;
		logic       run_last;
	} annexb_item_t;

	class annexb_scoreboard;
		logic [7:0] store[StoreDepth];
		int unsigned store_count, rec_phase, units_left, unit_left, flags;
		int unsigned len_accum, nal_left, byte_idx, len_size, err;
		bit first_nal;
		pkt_phase_t pphase;
		annexb_item_t pending[$];
		int errors;
		annexb_item_t step_items[$];

		function void clear();
			store_count = 0; rec_phase = 0; units_left = 0; unit_left = 0; flags = 0;
			pphase = PK_LEN; len_accum = 0; nal_left = 0; first_nal = 1; byte_idx = 0;
			len_size = 4; err = 0; errors = 0; pending.delete();
		endfunction

		function void push(logic st, logic [7:0] b, logic [2:0] code, logic [2:0] nls);
			annexb_item_t it;
			it.is_status = st; it.out_byte = b; it.status = code;
			it.nal_length_size = nls; it.run_last = 0;
			step_items.push_back(it);
		endfunction

		function void put_store(logic [7:0] b);
			if (store_count < StoreDepth) begin
				store[store_count] = b;
				store_count++;
			end else
				err = 2;
		endfunction

		function void unit_end();
			units_left = (units_left - 1) & 8'hff;
			if (units_left != 0)
				rec_phase = RecSizeHi;
			else if (flags & 4)
				rec_phase = RecDone;
			else begin
				flags |= 4;
				rec_phase = RecPpsCount;
			end
		endfunction

		function void start_code();
			if (first_nal)
				push(0, 8'h00, ST_OK, 3'd0);
			push(0, 8'h00, ST_OK, 3'd0);
			push(0, 8'h00, ST_OK, 3'd0);
			push(0, 8'h01, ST_OK, 3'd0);
			first_nal = 0;
		endfunction

		function void record_byte(logic [7:0] b);
			case (rec_phase)
				RecSkip0: begin
					store_count = 0; flags = 0; err = 0; units_left = 0; rec_phase = 1;
				end
				1, 2, 3: rec_phase++;
				RecLenSize: begin
					len_size = (b & 3) + 1; rec_phase = RecSpsCount;
				end
				RecSpsCount: begin
					units_left = b & 8'h1f;
					if (units_left == 0) begin
						flags |= 4; rec_phase = RecPpsCount;
					end else begin
						flags |= 1; rec_phase = RecSizeHi;
					end
				end
				RecSizeHi: begin
					unit_left = b << 8; rec_phase = RecSizeLo;
				end
				RecSizeLo: begin
					unit_left |= b;
					put_store(0); put_store(0); put_store(0); put_store(1);
					if (unit_left == 0)
						unit_end();
					else
						rec_phase = RecBody;
				end
				RecBody: begin
					put_store(b);
					unit_left = (unit_left - 1) & 16'hffff;
					if (unit_left == 0)
						unit_end();
				end
				RecPpsCount: begin
					units_left = b;
					if (b == 0)
						rec_phase = RecDone;
					else begin
						flags |= 2; rec_phase = RecSizeHi;
					end
				end
				default: rec_phase = RecDone;
			endcase
		endfunction

		function void packet_byte(logic [7:0] b);
			case (pphase)
				PK_LEN: begin
					len_accum = (len_accum << 8) | b;
					byte_idx++;
					if (byte_idx >= LengthBytes) begin
						byte_idx = 0; nal_left = len_accum; len_accum = 0;
						if (nal_left[31])
							pphase = PK_DISCARD;
						else if (nal_left == 0)
							start_code();
						else
							pphase = PK_START;
					end
				end
				PK_START, PK_BODY: begin
					if (pphase == PK_START) begin
						if (b[4:0] == NAL_IDR)
							for (int i = 0; i < store_count; i++)
								push(0, store[i], ST_OK, 3'd0);
						start_code();
					end
					push(0, b, ST_OK, 3'd0);
					nal_left--;
					pphase = (nal_left == 0) ? PK_LEN : PK_BODY;
				end
				default: ;
			endcase
		endfunction

		// Notes one accepted input transfer and queues the items it causes.
		function void note_input(logic op, logic [7:0] b, logic lst);
			logic [2:0] code;
			step_items.delete();
			if (op == OP_RECORD) begin
				record_byte(b);
				if (lst) begin
					if (rec_phase != RecDone) code = ST_REC_TRUNC;
					else if (err != 0) code = ST_OVERFLOW;
					else if (!(flags & 1)) code = ST_NO_SPS;
					else if (!(flags & 2)) code = ST_NO_PPS;
					else code = ST_OK;
					if (code == ST_REC_TRUNC || code == ST_OVERFLOW) begin
						store_count = 0; flags = 0;
					end
					push(1, 8'h00, code, 3'(len_size));
					rec_phase = RecSkip0;
				end
			end else begin
				packet_byte(b);
				if (lst) begin
					code = (pphase == PK_LEN && byte_idx == 0) ? ST_OK : ST_PKT_TRUNC;
					push(1, 8'h00, code, 3'(len_size));
					pphase = PK_LEN; byte_idx = 0; len_accum = 0; nal_left = 0;
					first_nal = 1;
				end
			end
			if (step_items.size() > 0)
				step_items[step_items.size() - 1].run_last = 1;
			foreach (step_items[i])
				pending.push_back(step_items[i]);
		endfunction

		function void check_output(annexb_item_t got);
			annexb_item_t exp;
			if (pending.size() == 0) begin
				$display("%0t: unexpected output item %p", $time, got);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got !== exp) begin
				$display("%0t: mismatch expected %p actual %p", $time, exp, got);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	a2a_in_if in_ch();
	a2a_out_if out_ch();
	annexb_scoreboard sb;
	int sent_count = 0;
	bit long_hold = 0;
	bit no_gaps = 0;

	avcc_to_annexb_converter_core i_dut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.out_ch(out_ch));

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("FAIL avcc_to_annexb_converter_core");
		$finish;
	end

	initial begin
		in_ch.valid = 0; in_ch.op = 0; in_ch.data_byte = 0; in_ch.last = 0;
		out_ch.ready = 0;
	end

	// Receiver: random stall pattern, plus one long hold-off on request; always ready while no_gaps is set.
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_ch.ready <= 0;
				for (hold = 0; hold < 400; hold++)
					@(posedge clk);
				long_hold = 0;
			end else if (no_gaps)
				out_ch.ready <= 1;
			else
				out_ch.ready <= ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		annexb_item_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.is_status = out_ch.is_status; got.out_byte = out_ch.out_byte;
			got.status = out_ch.status; got.nal_length_size = out_ch.nal_length_size;
			got.run_last = out_ch.run_last;
			sb.check_output(got);
		end
		if (arst_n && in_ch.valid && in_ch.ready)
			sb.note_input(in_ch.op, in_ch.data_byte, in_ch.last);
	end

	int burst_left = 0;

	// Offers one byte; gaps fall between bursts, and valid stays high within one.
	task automatic send_byte(logic op, logic [7:0] b, logic lst);
		int gap;
		if (!no_gaps && burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_ch.valid <= 0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		in_ch.valid <= 1; in_ch.op <= op; in_ch.data_byte <= b; in_ch.last <= lst;
		do @(posedge clk); while (!in_ch.ready);
		if (burst_left > 0)
			burst_left--;
		sent_count++;
	endtask

	task automatic go_idle();
		in_ch.valid <= 0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		int guard;
		in_ch.valid <= 0;
		guard = 0;
		do begin
			@(posedge clk);
			guard++;
		end while (sb.pending.size() != 0 && guard < 100000);
	endtask

	// Sends a record; a negative trailing count ends it early by that many bytes.
	task automatic send_record(int n_sps, int n_pps, int max_len, int trailing);
		logic [7:0] hdr[$];
		logic [7:0] bytes[$];
		for (int i = 0; i < 4; i++) hdr.push_back(8'($urandom_range(0, 255)));
		bytes = hdr;
		bytes.push_back({6'($urandom_range(0, 63)), 2'($urandom_range(0, 3))});
		bytes.push_back({3'($urandom_range(0, 7)), 5'(n_sps)});
		for (int i = 0; i < n_sps; i++) begin
			int l = $urandom_range(0, max_len);
			bytes.push_back(8'(l >> 8)); bytes.push_back(8'(l & 8'hff));
			for (int j = 0; j < l; j++) bytes.push_back(8'($urandom_range(0, 255)));
		end
		bytes.push_back(8'(n_pps));
		for (int i = 0; i < n_pps; i++) begin
			int l = $urandom_range(0, max_len);
			bytes.push_back(8'(l >> 8)); bytes.push_back(8'(l & 8'hff));
			for (int j = 0; j < l; j++) bytes.push_back(8'($urandom_range(0, 255)));
		end
		for (int i = 0; i < trailing; i++) bytes.push_back(8'($urandom_range(0, 255)));
		if (trailing < 0)
			bytes = bytes[0:bytes.size() - 1 + trailing];
		foreach (bytes[i])
			send_byte(OP_RECORD, bytes[i], i == bytes.size() - 1);
	endtask

	// Sends a packet of NALs with random lengths up to max_len; a cut drops that many tail bytes.
	task automatic send_packet(int n_nal, int max_len, bit idr, int cut);
		logic [7:0] bytes[$];
		for (int k = 0; k < n_nal; k++) begin
			int l = $urandom_range(0, max_len);
			bytes.push_back(8'h00); bytes.push_back(8'h00);
			bytes.push_back(8'(l >> 8)); bytes.push_back(8'(l & 8'hff));
			for (int j = 0; j < l; j++)
				if (j == 0 && idr && $urandom_range(0, 1))
					bytes.push_back({3'($urandom_range(0, 7)), NAL_IDR});
				else
					bytes.push_back(8'($urandom_range(0, 255)));
		end
		for (int i = 0; i < cut && bytes.size() > 1; i++)
			void'(bytes.pop_back());
		if (bytes.size() == 0) bytes.push_back(8'h00);
		foreach (bytes[i])
			send_byte(OP_PACKET, bytes[i], i == bytes.size() - 1);
	endtask

	initial begin
		int r;
		sb = new();
		sb.clear();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: good record, empty NAL, IDR with replay, negative length, truncations, records without SPS or PPS.
		send_record(1, 1, 3, 0);
		send_packet(1, 0, 0, 0);
		send_byte(OP_PACKET, 0, 0); send_byte(OP_PACKET, 0, 0);
		send_byte(OP_PACKET, 0, 0); send_byte(OP_PACKET, 2, 0);
		send_byte(OP_PACKET, 8'h65, 0); send_byte(OP_PACKET, 8'hff, 1);
		send_byte(OP_PACKET, 8'h80, 0); send_byte(OP_PACKET, 0, 0);
		send_byte(OP_PACKET, 0, 0); send_byte(OP_PACKET, 1, 0);
		send_byte(OP_PACKET, 8'h12, 1);
		send_packet(1, 3, 0, 1);
		send_record(0, 1, 2, 2);
		send_record(1, 0, 2, 0);
		send_record(1, 1, 2, -2);
		send_byte(OP_RECORD, 8'hff, 1);
		// Likely overflow, then a record of at most 56 store bytes, so it always fits.
		send_record(3, 2, 30, 0);
		wait_drained();
		send_record(2, 2, 10, 0);
		send_packet(2, 4, 1, 0);
		wait_drained();

		// The receiver holds off while the sender keeps offering.
		long_hold = 1;
		send_packet(3, 10, 1, 0);
		send_record(2, 1, 6, 0);
		wait_drained();
		no_gaps = 1;
		send_packet(2, 6, 1, 0);
		no_gaps = 0;

		while (sent_count < 350) begin
			r = $urandom_range(0, 9);
			if (r < 2)
				send_record($urandom_range(0, 3), $urandom_range(0, 3), 8,
					$urandom_range(0, 5) == 0 ? -$urandom_range(1, 3) : $urandom_range(0, 1));
			else if (r < 9)
				send_packet($urandom_range(1, 3), 6, 1,
					$urandom_range(0, 6) == 0 ? $urandom_range(1, 3) : 0);
			else
				send_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			if ($urandom_range(0, 15) == 0)
				wait_drained();
		end
		go_idle();
		wait_drained();
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("PASS avcc_to_annexb_converter_core");
		else
			$display("FAIL avcc_to_annexb_converter_core");
		$finish;
	end
endmodule
`default_nettype wire
